### rtl/bls_pkg.sv
// ----------------------------------------------------------------------------
// bls_pkg: shared types and constants for the line stepper
// Word layouts on both channels, the queue entry, coordinate and error widths.
// ----------------------------------------------------------------------------
package bls_pkg;

    localparam int COORD_BITS  = 8;
    localparam int ERR_BITS    = COORD_BITS + 2;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    localparam logic CMD_BEGIN = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    typedef logic [COORD_BITS-1:0]      coord_t;
    typedef logic signed [ERR_BITS-1:0] err_t;

    typedef struct packed {
        logic   command;
        coord_t from_x;
        coord_t from_y;
        coord_t to_x;
        coord_t to_y;
    } in_word_t;

    typedef struct packed {
        coord_t pixel_x;
        coord_t pixel_y;
        logic   last_pixel;
    } out_word_t;

    // classified command with the begin setup already worked out
    typedef struct packed {
        logic   is_step;
        coord_t from_x;
        coord_t from_y;
        coord_t to_x;
        coord_t to_y;
        coord_t span_x;
        coord_t span_y;
        logic   dir_x_neg;
        logic   dir_y_neg;
        err_t   err_init;
    } entry_t;

endpackage

### rtl/bls_front.sv
// ----------------------------------------------------------------------------
// bls_front: command decode and line setup
// Classifies the incoming word and computes spans, directions, initial error.
// ----------------------------------------------------------------------------
module bls_front (
    input  bls_pkg::in_word_t in_word,
    output bls_pkg::entry_t   entry
);

    bls_pkg::coord_t span_x;
    bls_pkg::coord_t span_y;
    bls_pkg::err_t   half_x;
    bls_pkg::err_t   half_y;

    always_comb begin
        span_x = (in_word.to_x >= in_word.from_x) ? (in_word.to_x - in_word.from_x)
                                                  : (in_word.from_x - in_word.to_x);
        span_y = (in_word.to_y >= in_word.from_y) ? (in_word.to_y - in_word.from_y)
                                                  : (in_word.from_y - in_word.to_y);
        half_x = bls_pkg::err_t'({2'b00, span_x >> 1});
        half_y = bls_pkg::err_t'({2'b00, span_y >> 1});

        entry.is_step   = (in_word.command == bls_pkg::CMD_STEP);
        entry.from_x    = in_word.from_x;
        entry.from_y    = in_word.from_y;
        entry.to_x      = in_word.to_x;
        entry.to_y      = in_word.to_y;
        entry.span_x    = span_x;
        entry.span_y    = span_y;
        entry.dir_x_neg = !(in_word.from_x < in_word.to_x);
        entry.dir_y_neg = !(in_word.from_y < in_word.to_y);
        entry.err_init  = (span_x > span_y) ? half_x : -half_y;
    end

endmodule

### rtl/bls_queue.sv
// ----------------------------------------------------------------------------
// bls_queue: short queue between decode and stepper
// Register based, one push and one pop per cycle.
// ----------------------------------------------------------------------------
module bls_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  bls_pkg::entry_t push_entry,
    output logic            full,
    input  logic            pop,
    output logic            empty,
    output bls_pkg::entry_t head
);

    bls_pkg::entry_t                  slot_reg [bls_pkg::QUEUE_DEPTH];
    logic [bls_pkg::QPTR_BITS-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [bls_pkg::QPTR_BITS-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [bls_pkg::QCNT_BITS-1:0]    count_reg, count_next;

    localparam logic [bls_pkg::QCNT_BITS-1:0] DepthCnt =
        bls_pkg::QCNT_BITS'(bls_pkg::QUEUE_DEPTH);
    localparam logic [bls_pkg::QPTR_BITS-1:0] LastPtr =
        bls_pkg::QPTR_BITS'(bls_pkg::QUEUE_DEPTH - 1);

    assign full  = (count_reg == DepthCnt);
    assign empty = (count_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= DepthCnt)
        else $error("queue count over depth");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full && !pop))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && empty))
        else $error("pop from empty queue");

endmodule

### rtl/bls_back.sv
// ----------------------------------------------------------------------------
// bls_back: line stepper and output register
// Holds the line state, loads it on a begin word, runs one Bresenham step per step word, drives the output.
// ----------------------------------------------------------------------------
module bls_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_empty,
    input  bls_pkg::entry_t    q_head,
    output logic               q_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output bls_pkg::out_word_t m_data
);

    bls_pkg::coord_t    cur_x_reg, cur_x_next;
    bls_pkg::coord_t    cur_y_reg, cur_y_next;
    bls_pkg::coord_t    goal_x_reg, goal_x_next;
    bls_pkg::coord_t    goal_y_reg, goal_y_next;
    bls_pkg::coord_t    span_x_reg, span_x_next;
    bls_pkg::coord_t    span_y_reg, span_y_next;
    logic               dir_x_neg_reg, dir_x_neg_next;
    logic               dir_y_neg_reg, dir_y_neg_next;
    bls_pkg::err_t      err_reg, err_next;
    logic               active_reg, active_next;
    logic               out_valid_reg, out_valid_next;
    bls_pkg::out_word_t out_data_reg, out_data_next;

    logic               out_free;
    logic               emit;
    logic               move_x, move_y;
    logic               done;
    bls_pkg::err_t      sx_e, sy_e;

    assign out_free = !out_valid_reg || m_ready;
    assign q_pop    = !q_empty && out_free;
    // a step with no line in progress is consumed silently
    assign emit     = q_pop && (!q_head.is_step || active_reg);

    assign m_valid  = out_valid_reg;
    assign m_data   = out_data_reg;

    always_comb begin
        sx_e = bls_pkg::err_t'({2'b00, span_x_reg});
        sy_e = bls_pkg::err_t'({2'b00, span_y_reg});
        // both tests see the error from before the step
        move_x = (err_reg > -sx_e);
        move_y = (err_reg < sy_e);

        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        goal_x_next    = goal_x_reg;
        goal_y_next    = goal_y_reg;
        span_x_next    = span_x_reg;
        span_y_next    = span_y_reg;
        dir_x_neg_next = dir_x_neg_reg;
        dir_y_neg_next = dir_y_neg_reg;
        err_next       = err_reg;

        if (q_pop && !q_head.is_step) begin
            cur_x_next     = q_head.from_x;
            cur_y_next     = q_head.from_y;
            goal_x_next    = q_head.to_x;
            goal_y_next    = q_head.to_y;
            span_x_next    = q_head.span_x;
            span_y_next    = q_head.span_y;
            dir_x_neg_next = q_head.dir_x_neg;
            dir_y_neg_next = q_head.dir_y_neg;
            err_next       = q_head.err_init;
        end else if (emit) begin
            err_next = err_reg - (move_x ? sy_e : '0) + (move_y ? sx_e : '0);
            if (move_x) begin
                cur_x_next = dir_x_neg_reg ? cur_x_reg - 1'b1 : cur_x_reg + 1'b1;
            end
            if (move_y) begin
                cur_y_next = dir_y_neg_reg ? cur_y_reg - 1'b1 : cur_y_reg + 1'b1;
            end
        end

        done = (cur_x_next == goal_x_next) && (cur_y_next == goal_y_next);

        active_next = active_reg;
        if (emit) begin
            active_next = !done;
        end

        out_data_next.pixel_x    = cur_x_next;
        out_data_next.pixel_y    = cur_y_next;
        out_data_next.last_pixel = done;

        out_valid_next = out_valid_reg;
        if (emit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            goal_x_reg    <= '0;
            goal_y_reg    <= '0;
            span_x_reg    <= '0;
            span_y_reg    <= '0;
            dir_x_neg_reg <= 1'b0;
            dir_y_neg_reg <= 1'b0;
            err_reg       <= '0;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            cur_x_reg     <= cur_x_next;
            cur_y_reg     <= cur_y_next;
            goal_x_reg    <= goal_x_next;
            goal_y_reg    <= goal_y_next;
            span_x_reg    <= span_x_next;
            span_y_reg    <= span_y_next;
            dir_x_neg_reg <= dir_x_neg_next;
            dir_y_neg_reg <= dir_y_neg_next;
            err_reg       <= err_next;
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            out_data_reg <= out_data_next;
        end
    end

    // emitted endpoint always closes the line, any other pixel keeps it open
    a_last_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |=> (out_data_reg.last_pixel == !active_reg))
        else $error("last_pixel and active disagree");

    // an idle step leaves position and error alone
    a_idle_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && q_head.is_step && !active_reg) |=>
            ($stable(cur_x_reg) && $stable(cur_y_reg) && $stable(err_reg) && !active_reg))
        else $error("idle step changed line state");

    // begin loads the start point as the emitted pixel
    a_begin_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && !q_head.is_step) |=>
            (out_valid_reg && out_data_reg.pixel_x == $past(q_head.from_x)
             && out_data_reg.pixel_y == $past(q_head.from_y)))
        else $error("begin did not emit start pixel");

endmodule

### rtl/bresenham_line_stepper.sv
// ----------------------------------------------------------------------------
// bresenham_line_stepper: all-octant integer line rasterizer
// Begin words set up a line and give its start pixel; step words give the next.
// ----------------------------------------------------------------------------
//
//  channel   ports                      word type             role
//  input     s_valid s_ready s_data     bls_pkg::in_word_t    begin / step commands
//  output    m_valid m_ready m_data     bls_pkg::out_word_t   pixel, last_pixel flag
//
//  One word per clock sustained while m_ready stays high; a word is decoded into
//  the queue at the accepting edge, then the step unit moves it from the queue
//  head into the output register once the output is free.
//  The step unit's single error update and coordinate increment set that rate.
//  Reset (aresetn low, synchronous) empties the queue, clears the line state
//  and drops m_valid. A stall on m_ready holds the output register; the
//  two-entry queue keeps s_ready high until it fills.
//  A step with no line in progress is consumed and gives no pixel.
//
module bresenham_line_stepper (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  bls_pkg::in_word_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output bls_pkg::out_word_t m_data
);

    bls_pkg::entry_t front_entry;
    bls_pkg::entry_t q_head;
    logic            q_full;
    logic            q_empty;
    logic            q_pop;
    logic            q_push;

    // front: classify and precompute begin setup, no state
    bls_front u_front (
        .in_word (s_data),
        .entry   (front_entry)
    );

    assign s_ready = !q_full;
    assign q_push  = s_valid && s_ready;

    // decoupling queue, lets the input side run while output stalls
    bls_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (front_entry),
        .full       (q_full),
        .pop        (q_pop),
        .empty      (q_empty),
        .head       (q_head)
    );

    // back: line state, one Bresenham step per step word, output register
    bls_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_empty (q_empty),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

### tb/bls_pixel_checker.sv
// ----------------------------------------------------------------------------
// bls_pixel_checker: pixel predictor and scoreboard for the line stepper
// Watches both channels and traces each accepted command through its own copy
// of the line state. Every accepted pixel word is checked against the oldest
// pixel still owed.
// ----------------------------------------------------------------------------
module bls_pixel_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  bls_pkg::in_word_t  s_data,
    input  logic               m_valid,
    input  logic               m_ready,
    input  bls_pkg::out_word_t m_data,
    output int                 fail_count,
    output int                 pixels_owed
);
    import bls_pkg::*;

    // predicted line state
    coord_t cur_x, cur_y, goal_x, goal_y, span_x, span_y;
    logic   dir_x_neg, dir_y_neg, line_active;
    err_t   error_acc;

    out_word_t owed_pixels[$];
    int        fault_total = 0;
    int        owed_total  = 0;

    assign fail_count  = fault_total;
    assign pixels_owed = owed_total;

    task automatic report_fault(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        fault_total++;
    endtask

    // one command through the line state; queues the pixel it gives, if any
    task automatic advance_raster(input in_word_t w);
        int        e_old;
        int        sx;
        int        sy;
        out_word_t px;
        if (w.command == CMD_BEGIN) begin
            cur_x     = w.from_x;
            cur_y     = w.from_y;
            goal_x    = w.to_x;
            goal_y    = w.to_y;
            dir_x_neg = !(w.from_x < w.to_x);
            dir_y_neg = !(w.from_y < w.to_y);
            span_x    = (w.to_x >= w.from_x) ? w.to_x - w.from_x : w.from_x - w.to_x;
            span_y    = (w.to_y >= w.from_y) ? w.to_y - w.from_y : w.from_y - w.to_y;
            if (span_x > span_y) begin
                error_acc = err_t'(int'(span_x >> 1));
            end else begin
                error_acc = err_t'(-int'(span_y >> 1));
            end
            line_active = 1'b1;
        end else begin
            if (!line_active) return;
            // both tests look at the error from before this step
            e_old = int'(error_acc);
            sx    = int'(span_x);
            sy    = int'(span_y);
            if (e_old > -sx) begin
                error_acc = err_t'(int'(error_acc) - sy);
                cur_x     = dir_x_neg ? cur_x - 1'b1 : cur_x + 1'b1;
            end
            if (e_old < sy) begin
                error_acc = err_t'(int'(error_acc) + sx);
                cur_y     = dir_y_neg ? cur_y - 1'b1 : cur_y + 1'b1;
            end
        end
        px.pixel_x    = cur_x;
        px.pixel_y    = cur_y;
        px.last_pixel = (cur_x == goal_x) && (cur_y == goal_y);
        if (px.last_pixel) line_active = 1'b0;
        owed_pixels.push_back(px);
    endtask

    always @(posedge aclk) begin
        out_word_t want;
        if (!aresetn) begin
            cur_x       = '0;
            cur_y       = '0;
            goal_x      = '0;
            goal_y      = '0;
            span_x      = '0;
            span_y      = '0;
            dir_x_neg   = 1'b0;
            dir_y_neg   = 1'b0;
            error_acc   = '0;
            line_active = 1'b0;
            owed_pixels.delete();
        end else begin
            // output side first; a word taken now cannot show up this edge
            if (m_valid && m_ready) begin
                if (owed_pixels.size() == 0) begin
                    report_fault($sformatf("unexpected pixel (%0d,%0d) last=%0b",
                        m_data.pixel_x, m_data.pixel_y, m_data.last_pixel));
                end else begin
                    want = owed_pixels.pop_front();
                    if (m_data.pixel_x !== want.pixel_x)
                        report_fault($sformatf("pixel_x got %0d want %0d",
                            m_data.pixel_x, want.pixel_x));
                    if (m_data.pixel_y !== want.pixel_y)
                        report_fault($sformatf("pixel_y got %0d want %0d",
                            m_data.pixel_y, want.pixel_y));
                    if (m_data.last_pixel !== want.last_pixel)
                        report_fault($sformatf("last_pixel got %0b want %0b at (%0d,%0d)",
                            m_data.last_pixel, want.last_pixel,
                            want.pixel_x, want.pixel_y));
                end
            end
            if (s_valid && s_ready) advance_raster(s_data);
        end
        owed_total = owed_pixels.size();
    end

endmodule

### tb/bresenham_line_stepper_tb.sv
// ----------------------------------------------------------------------------
// bresenham_line_stepper_tb: stimulus and verdict for the line stepper
// Directed diagonal, steep and horizontal lines plus the corner cases, then random lines,
// mostly traced to their end, some abandoned or overstepped. Both channels
// idle at random; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module bresenham_line_stepper_tb;
    import bls_pkg::*;

    localparam int HALF_PERIOD  = 6;
    localparam int QUIET_LIMIT  = 2000;   // cycles with no word moving on either side
    localparam int DRAIN_CYCLES = 8;
    localparam int WORD_TARGET  = 400;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_word_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_word_t m_data;

    int fail_count;
    int pixels_owed;
    int idle_pct   = 7;   // chance in a hundred that a side idles this cycle
    int quiet_cycles = 0;
    int words_counted = 0; // words that give a pixel

    bresenham_line_stepper u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    bls_pixel_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .fail_count  (fail_count),
        .pixels_owed (pixels_owed)
    );

    initial begin
        forever #HALF_PERIOD aclk = ~aclk;
    end

    // result side backpressure, changed on the falling edge only
    initial begin
        forever begin
            @(negedge aclk);
            m_ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // watchdog: a hung handshake ends the run
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles + 1 >= QUIET_LIMIT) begin
                $display("bresenham_line_stepper test failed");
                $finish;
            end
        end
    end

    // Offer one word. Valid is only lowered for a random idle gap; after an
    // accept it stays up so back-to-back words go with no gap in valid.
    task automatic send_word(input in_word_t w);
        @(negedge aclk);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic send_begin(input coord_t fx, input coord_t fy,
                              input coord_t tx, input coord_t ty);
        in_word_t w;
        w.command = CMD_BEGIN;
        w.from_x  = fx;
        w.from_y  = fy;
        w.to_x    = tx;
        w.to_y    = ty;
        send_word(w);
        words_counted++;
    endtask

    // step words carry junk in the unused coordinate fields
    task automatic send_step(input bit gives_pixel);
        in_word_t w;
        w         = in_word_t'($urandom);
        w.command = CMD_STEP;
        send_word(w);
        if (gives_pixel) words_counted++;
    endtask

    function automatic int line_steps(input coord_t fx, input coord_t fy,
                                      input coord_t tx, input coord_t ty);
        int dx;
        int dy;
        dx = (tx >= fx) ? int'(tx - fx) : int'(fx - tx);
        dy = (ty >= fy) ? int'(ty - fy) : int'(fy - ty);
        return (dx > dy) ? dx : dy;
    endfunction

    initial begin
        coord_t fx, fy, tx, ty;
        int     steps_total;
        int     steps_sent;
        int     extra;
        int     shape_roll;
        int     tail_roll;
        coord_t dxv, dyv;

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // ---- directed ----
        // step before any line exists: swallowed
        send_step(1'b0);
        // full diagonal from the origin, abandoned after two steps
        send_begin(8'd0, 8'd0, 8'd255, 8'd255);
        send_step(1'b1);
        send_step(1'b1);
        // begin while a line is active: old one dropped, reverse diagonal
        send_begin(8'd255, 8'd255, 8'd0, 8'd0);
        send_step(1'b1);
        send_step(1'b1);
        // zero-length line: single last pixel, following step gives nothing
        send_begin(8'd255, 8'd0, 8'd255, 8'd0);
        send_step(1'b0);
        // anti-diagonal across the whole raster
        send_begin(8'd0, 8'd255, 8'd255, 8'd0);
        send_step(1'b1);
        // steep line, x up, y down, traced to its endpoint
        send_begin(8'd10, 8'd10, 8'd13, 8'd5);
        repeat (5) send_step(1'b1);
        // past the endpoint: no pixel
        send_step(1'b0);
        // horizontal, x down, traced fully
        send_begin(8'd200, 8'd3, 8'd197, 8'd3);
        repeat (3) send_step(1'b1);

        // ---- random lines ----
        while (words_counted < WORD_TARGET) begin
            // a stretch with no idling on either side
            idle_pct = (words_counted >= 150 && words_counted < 250) ? 0 : 7;

            fx         = coord_t'($urandom);
            fy         = coord_t'($urandom);
            shape_roll = $urandom_range(99);
            if (shape_roll < 3 && words_counted < 250) begin
                // rare long line anywhere on the raster
                tx = coord_t'($urandom);
                ty = coord_t'($urandom);
            end else begin
                dxv = coord_t'($urandom_range(16));
                dyv = coord_t'($urandom_range(16));
                tx  = $urandom_range(1) ? fx - dxv : fx + dxv;
                ty  = $urandom_range(1) ? fy - dyv : fy + dyv;
                if (shape_roll < 8) ty = fy;        // horizontal
                else if (shape_roll < 13) tx = fx;  // vertical
            end

            steps_total = line_steps(fx, fy, tx, ty);
            tail_roll   = $urandom_range(99);
            steps_sent  = steps_total;
            extra       = 0;
            if (tail_roll < 15) begin
                steps_sent = $urandom_range(steps_total);   // abandon early
            end else if (tail_roll < 25) begin
                extra = $urandom_range(2, 1);               // overstep the end
            end

            send_begin(fx, fy, tx, ty);
            repeat (steps_sent) send_step(1'b1);
            repeat (extra) send_step(1'b0);
        end

        @(negedge aclk);
        s_valid <= 1'b0;

        // drain, then allow the pipeline to show any stray word
        while (pixels_owed != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0 && pixels_owed == 0) begin
            $display("bresenham_line_stepper test passed");
        end else begin
            $display("bresenham_line_stepper test failed");
        end
        $finish;
    end

endmodule
